>>> design/bup_pkg.sv
// Shared types and constants for the boot upload mailbox handshake.
`default_nettype none
package bup_pkg;

    localparam logic [7:0] SIGNAL_BYTE = 8'hCC;
    localparam logic [7:0] PORT0_RESET = 8'hAA;
    localparam logic [7:0] PORT1_VALUE = 8'hBB;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [1:0] PORT_0 = 2'd0;
    localparam logic [1:0] PORT_1 = 2'd1;
    localparam logic [1:0] PORT_2 = 2'd2;
    localparam logic [1:0] PORT_3 = 2'd3;

    localparam logic [2:0] PHASE_WAIT_SIGNAL = 3'd0;
    localparam logic [2:0] PHASE_BEGIN       = 3'd1;
    localparam logic [2:0] PHASE_XFER_START  = 3'd2;
    localparam logic [2:0] PHASE_WAIT_INDEX  = 3'd3;
    localparam logic [2:0] PHASE_EXECUTE     = 3'd4;

    typedef struct packed {
        logic       req_type;
        logic [1:0] port_index;
        logic [7:0] write_data;
    } bup_req_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [2:0]  phase;
        logic [15:0] transfer_address;
    } bup_rsp_t;

    typedef struct packed {
        logic valid;
        logic take;
    } bup_hs_t;

endpackage
`default_nettype wire

>>> design/bup_in_stage.sv
// Input register stage that holds one accepted request transaction.
`default_nettype none
module bup_in_stage
    import bup_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire bup_req_t req,
    input  wire logic     take,
    output bup_hs_t       hs,
    output bup_req_t      item
);

    logic     valid_reg;
    logic     valid_next;
    bup_req_t item_reg;

    assign req_ready  = !valid_reg || take;
    assign valid_next = (req_valid && req_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            item_reg <= req;
        end
    end

    assign hs.valid = valid_reg;
    assign hs.take  = take;
    assign item     = item_reg;

endmodule
`default_nettype wire

>>> design/bup_core.sv
// Mailbox port state and five-phase boot handshake update.
`default_nettype none
module bup_core
    import bup_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire bup_hs_t  hs,
    input  wire bup_req_t item,
    output bup_rsp_t      result
);

    typedef enum logic [2:0] {
        PH_WAIT_SIGNAL = 3'd0,
        PH_BEGIN       = 3'd1,
        PH_XFER_START  = 3'd2,
        PH_WAIT_INDEX  = 3'd3,
        PH_EXECUTE     = 3'd4
    } phase_t;

    logic [7:0]  ports_reg [4];
    logic [7:0]  ports_next [4];
    logic [7:0]  out0_reg;
    logic [7:0]  out0_next;
    phase_t      phase_reg;
    phase_t      phase_next;
    logic [15:0] addr_reg;
    logic [15:0] addr_next;
    logic [7:0]  idx_reg;
    logic [7:0]  idx_next;
    logic [7:0]  p0;
    logic [15:0] latched;
    logic        wr_fire;

    assign wr_fire = hs.valid && hs.take && (item.req_type == REQ_WRITE);

    always_comb
    begin
        ports_next = ports_reg;
        if (wr_fire)
        begin
            ports_next[item.port_index] = item.write_data;
        end
    end

    assign p0      = ports_next[0];
    assign latched = {ports_next[3], ports_next[2]};

    always_comb
    begin
        phase_next = phase_reg;
        out0_next  = out0_reg;
        addr_next  = addr_reg;
        idx_next   = idx_reg;
        if (wr_fire)
        begin
            case (phase_reg)
                PH_WAIT_SIGNAL:
                begin
                    if (p0 == SIGNAL_BYTE)
                    begin
                        phase_next = PH_BEGIN;
                        addr_next  = latched;
                        out0_next  = p0;
                    end
                end
                PH_BEGIN:
                begin
                    phase_next = (ports_next[1] == 8'd0) ? PH_EXECUTE : PH_XFER_START;
                end
                PH_XFER_START:
                begin
                    if (p0 == 8'd0)
                    begin
                        phase_next = PH_WAIT_INDEX;
                        out0_next  = p0;
                        addr_next  = addr_reg + 16'd1;
                        idx_next   = 8'd1;
                    end
                end
                PH_WAIT_INDEX:
                begin
                    if (p0 == idx_reg)
                    begin
                        out0_next = p0;
                        addr_next = addr_reg + 16'd1;
                        idx_next  = idx_reg + 8'd1;
                    end
                    else if (p0 > idx_reg)
                    begin
                        phase_next = PH_BEGIN;
                        out0_next  = p0;
                        addr_next  = latched;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        result.read_data = 8'd0;
        if (item.req_type == REQ_READ)
        begin
            case (item.port_index)
                PORT_0:  result.read_data = out0_reg;
                PORT_1:  result.read_data = PORT1_VALUE;
                default: result.read_data = 8'd0;
            endcase
        end
        result.phase            = phase_next;
        result.transfer_address = addr_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ports_reg <= '{default: 8'd0};
            out0_reg  <= PORT0_RESET;
            phase_reg <= PH_WAIT_SIGNAL;
            addr_reg  <= 16'd0;
        end
        else
        begin
            ports_reg <= ports_next;
            out0_reg  <= out0_next;
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
    end

endmodule
`default_nettype wire

>>> design/bup_out_stage.sv
// Result register stage that holds one response transaction until taken.
`default_nettype none
module bup_out_stage
    import bup_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     load,
    input  wire bup_rsp_t result,
    output logic          space,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output bup_rsp_t      rsp
);

    logic     valid_reg;
    logic     valid_next;
    bup_rsp_t rsp_reg;

    assign space      = !valid_reg || rsp_ready;
    assign valid_next = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

>>> design/boot_upload_port_handshake.sv
// Top level of the boot upload mailbox handshake.
// A request transaction is registered, then its response is registered.
// One transaction per cycle unless rsp_ready stalls; each write updates the port state.
// Reset (rst_n, async, active low): inbound ports 0, outbound port 0 = 0xAA,
// phase = wait for signal, address 0, both stages empty.
`default_nettype none
module boot_upload_port_handshake
    import bup_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire bup_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output bup_rsp_t      rsp
);

    bup_hs_t  hs;
    bup_req_t item;
    bup_rsp_t result;
    logic     space;
    logic     take;

    assign take = hs.valid && space;

    bup_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .take      (take),
        .hs        (hs),
        .item      (item)
    );

    bup_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .hs     (hs),
        .item   (item),
        .result (result)
    );

    bup_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .result    (result),
        .space     (space),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

>>> design/bup_checker.sv
// Port-level checker for the boot upload handshake and its bind.
`default_nettype none
module bup_checker
    import bup_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     rsp_valid,
    input wire logic     rsp_ready,
    input wire bup_rsp_t rsp
);

    logic seen_exec_reg;
    logic left_wait_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_exec_reg <= 1'b0;
            left_wait_reg <= 1'b0;
        end
        else if (rsp_valid && rsp_ready)
        begin
            seen_exec_reg <= seen_exec_reg || (rsp.phase == PHASE_EXECUTE);
            left_wait_reg <= left_wait_reg || (rsp.phase != PHASE_WAIT_SIGNAL);
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.phase <= PHASE_EXECUTE)
        else $error("phase code out of range");

    a_exec_terminal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && seen_exec_reg |-> rsp.phase == PHASE_EXECUTE)
        else $error("phase left execute");

    a_no_wait_return: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && left_wait_reg |-> rsp.phase != PHASE_WAIT_SIGNAL)
        else $error("phase returned to wait for signal");

    a_wait_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.phase == PHASE_WAIT_SIGNAL |-> rsp.transfer_address == 16'd0)
        else $error("address moved before signal byte");

endmodule

bind boot_upload_port_handshake bup_checker u_bup_checker (.*);
`default_nettype wire

>>> tb/sv/tb_boot_upload_port_handshake.sv
// Testbench for the boot upload mailbox: queued host accesses, self-checking against a local predictor.
`default_nettype none
module tb_boot_upload_port_handshake;
    import bup_pkg::*;

    localparam int IDLE_PCT    = 21;
    localparam int CALM_FIRST  = 150;
    localparam int CALM_LAST   = 230;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 40;

    typedef struct packed {
        bup_req_t acc;
        logic     drain;
    } host_access_t;

    logic     clk;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    bup_req_t req = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    bup_rsp_t rsp;

    host_access_t port_access_q[$];
    bup_rsp_t     replies_due[$];

    logic [7:0]  mb_inbound[4];
    logic [7:0]  mb_out0;
    logic [2:0]  mb_phase;
    logic [15:0] mb_addr;
    logic [7:0]  mb_index;

    int accesses_done = 0;
    int replies_seen = 0;
    int mismatches = 0;
    int writes_done = 0;
    int reads_done = 0;
    int bytes_acked = 0;
    int restarts = 0;
    int hold_left = 0;
    int accesses_queued = 0;
    logic [7:0] gen_port1;
    host_access_t next_access;
    bup_rsp_t want;

    boot_upload_port_handshake uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("** boot_upload_port_handshake: FAILED **");
        $finish;
    end

    task automatic mailbox_reset();
        for (int i = 0; i < 4; i++)
            mb_inbound[i] = 8'h00;
        mb_out0  = PORT0_RESET;
        mb_phase = PHASE_WAIT_SIGNAL;
        mb_addr  = 16'h0000;
        mb_index = 8'h00;
    endtask

    task automatic predict_access(input bup_req_t a);
        bup_rsp_t r;
        logic [7:0] p0;
        r = '0;
        if (a.req_type == REQ_WRITE)
        begin
            writes_done++;
            mb_inbound[a.port_index] = a.write_data;
            p0 = mb_inbound[0];
            case (mb_phase)
                PHASE_WAIT_SIGNAL:
                    if (p0 == SIGNAL_BYTE)
                    begin
                        mb_phase = PHASE_BEGIN;
                        mb_addr  = {mb_inbound[3], mb_inbound[2]};
                        mb_out0  = p0;
                    end
                PHASE_BEGIN:
                    mb_phase = (mb_inbound[1] == 8'h00) ? PHASE_EXECUTE : PHASE_XFER_START;
                PHASE_XFER_START:
                    if (p0 == 8'h00)
                    begin
                        mb_phase = PHASE_WAIT_INDEX;
                        mb_out0  = p0;
                        mb_addr  = mb_addr + 16'd1;
                        mb_index = 8'd1;
                        bytes_acked++;
                    end
                PHASE_WAIT_INDEX:
                    if (p0 == mb_index)
                    begin
                        mb_out0  = p0;
                        mb_addr  = mb_addr + 16'd1;
                        mb_index = mb_index + 8'd1;
                        bytes_acked++;
                    end
                    else if (p0 > mb_index)
                    begin
                        mb_phase = PHASE_BEGIN;
                        mb_out0  = p0;
                        mb_addr  = {mb_inbound[3], mb_inbound[2]};
                        restarts++;
                    end
                default:
                    ;
            endcase
        end
        else
        begin
            reads_done++;
            case (a.port_index)
                PORT_0:  r.read_data = mb_out0;
                PORT_1:  r.read_data = PORT1_VALUE;
                default: r.read_data = 8'h00;
            endcase
        end
        r.phase = mb_phase;
        r.transfer_address = mb_addr;
        replies_due.push_back(r);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            mailbox_reset();
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                predict_access(req);
                accesses_done++;
            end
            if (!req_valid || req_ready)
            begin
                if (port_access_q.size() != 0
                    && !(port_access_q[0].drain && replies_due.size() != 0)
                    && ((accesses_done >= CALM_FIRST && accesses_done < CALM_LAST)
                        || $urandom_range(99) >= IDLE_PCT))
                begin
                    next_access = port_access_q.pop_front();
                    req_valid <= 1'b1;
                    req <= next_access.acc;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                replies_seen++;
                if (replies_due.size() == 0)
                begin
                    $error("response with no request outstanding: read_data %h phase %0d addr %h",
                           rsp.read_data, rsp.phase, rsp.transfer_address);
                    mismatches++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (want.read_data !== rsp.read_data)
                    begin
                        $error("read_data: expected %h, got %h", want.read_data, rsp.read_data);
                        mismatches++;
                    end
                    if (want.phase !== rsp.phase)
                    begin
                        $error("phase: expected %0d, got %0d", want.phase, rsp.phase);
                        mismatches++;
                    end
                    if (want.transfer_address !== rsp.transfer_address)
                    begin
                        $error("transfer_address: expected %h, got %h",
                               want.transfer_address, rsp.transfer_address);
                        mismatches++;
                    end
                end
                if (replies_seen == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (replies_seen >= CALM_FIRST && replies_seen < CALM_LAST)
                rsp_ready <= 1'b1;
            else
                rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic queue_access(input logic kind, input logic [1:0] port,
                                input logic [7:0] data, input logic drain = 1'b0);
        host_access_t h;
        h.acc.req_type   = kind;
        h.acc.port_index = port;
        h.acc.write_data = data;
        h.drain = drain;
        port_access_q.push_back(h);
        accesses_queued++;
    endtask

    task automatic queue_read_noise();
        queue_access(REQ_READ, 2'($urandom_range(3)), 8'($urandom));
    endtask

    task automatic queue_upload_session(input int nbytes, input int noise_pct);
        logic [7:0] idx;
        logic [1:0] port;
        logic [7:0] data;
        repeat ($urandom_range(2))
            queue_read_noise();
        case ($urandom_range(3))
            0:
                queue_access(REQ_WRITE, PORT_0, 8'($urandom_range(255, 1)));
            1:
                if (gen_port1 != 8'h00)
                    queue_access(REQ_WRITE, 2'($urandom_range(3, 2)), 8'($urandom));
                else
                begin
                    gen_port1 = 8'($urandom_range(255, 1));
                    queue_access(REQ_WRITE, PORT_1, gen_port1);
                end
            default:
            begin
                gen_port1 = 8'($urandom_range(255, 1));
                queue_access(REQ_WRITE, PORT_1, gen_port1);
            end
        endcase
        repeat ($urandom_range(2))
        begin
            if ($urandom_range(1) == 0)
                queue_read_noise();
            else if ($urandom_range(1) == 0)
                queue_access(REQ_WRITE, PORT_0, 8'($urandom_range(255, 1)));
            else
            begin
                port = 2'($urandom_range(3, 1));
                data = 8'($urandom);
                if (port == PORT_1)
                    gen_port1 = data;
                queue_access(REQ_WRITE, port, data);
            end
        end
        queue_access(REQ_WRITE, PORT_0, 8'h00);
        idx = 8'd1;
        for (int k = 0; k < nbytes || idx == 8'hFF; k++)
        begin
            if ($urandom_range(99) < noise_pct)
            begin
                if ($urandom_range(2) == 0 || idx == 8'h00)
                    queue_read_noise();
                else if ($urandom_range(1) == 0)
                    queue_access(REQ_WRITE, PORT_0, 8'($urandom_range(int'(idx) - 1, 0)));
                else
                begin
                    port = 2'($urandom_range(3, 1));
                    data = 8'($urandom);
                    if (port == PORT_1)
                        gen_port1 = data;
                    queue_access(REQ_WRITE, port, data);
                end
            end
            queue_access(REQ_WRITE, PORT_0, idx);
            idx = idx + 8'd1;
        end
        queue_access(REQ_WRITE, PORT_0, 8'($urandom_range(255, int'(idx) + 1)));
    endtask

    initial
    begin
        queue_access(REQ_READ, PORT_0, 8'h00);
        queue_access(REQ_READ, PORT_1, 8'hFF);
        queue_access(REQ_READ, PORT_2, 8'h00);
        queue_access(REQ_READ, PORT_3, 8'hFF);
        queue_access(REQ_WRITE, PORT_2, 8'hFF);
        queue_access(REQ_WRITE, PORT_3, 8'hFF);
        queue_access(REQ_WRITE, PORT_0, 8'hCD);
        queue_access(REQ_WRITE, PORT_0, 8'hCB);
        queue_access(REQ_WRITE, PORT_1, 8'h00);
        queue_access(REQ_WRITE, PORT_0, SIGNAL_BYTE);
        queue_access(REQ_READ, PORT_0, 8'h00);
        queue_access(REQ_WRITE, PORT_1, 8'hFF);
        queue_access(REQ_WRITE, PORT_0, 8'h01);
        queue_access(REQ_WRITE, PORT_0, 8'h00);
        queue_access(REQ_WRITE, PORT_0, 8'h01);
        queue_access(REQ_WRITE, PORT_0, 8'h00);
        queue_access(REQ_WRITE, PORT_2, 8'h00);
        queue_access(REQ_WRITE, PORT_3, 8'h80);
        queue_access(REQ_WRITE, PORT_0, 8'h02);
        queue_access(REQ_READ, PORT_0, 8'h00);
        queue_access(REQ_WRITE, PORT_0, 8'h80);
        queue_access(REQ_READ, PORT_0, 8'h00);
        gen_port1 = 8'hFF;

        // hold the last directed access until all the accesses before it are answered
        port_access_q[port_access_q.size() - 1].drain = 1'b1;
        while (accesses_queued < 60)
            queue_upload_session($urandom_range(12), 25);
        queue_upload_session(260, 10);
        while (accesses_queued < 400)
            queue_upload_session($urandom_range(12), 30);

        queue_access(REQ_WRITE, PORT_1, 8'h00, 1'b1);
        queue_access(REQ_WRITE, PORT_0, SIGNAL_BYTE);
        queue_access(REQ_WRITE, PORT_0, 8'h00);
        queue_access(REQ_READ, PORT_0, 8'h00);
        queue_access(REQ_READ, PORT_1, 8'h00);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (port_access_q.size() != 0 || req_valid || replies_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (replies_due.size() != 0)
        begin
            $error("%0d responses never arrived", replies_due.size());
            mismatches++;
        end

        $display("Covered %0d transactions (%0d writes, %0d reads), %0d bytes acknowledged,",
                 accesses_done, writes_done, reads_done, bytes_acked);
        $display("%0d upload restarts, index wrap, and the execute phase; %0d mismatches.",
                 restarts, mismatches);
        if (mismatches == 0)
            $display("** boot_upload_port_handshake: PASSED **");
        else
            $display("** boot_upload_port_handshake: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire
